[rtl/core/i2c_bitbang_master_macros.svh]
// Assertion helpers for the I2C bit-bang master.
`ifndef I2C_BITBANG_MASTER_MACROS_SVH
`define I2C_BITBANG_MASTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define I2CBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/i2cbb_pkg.sv]
package i2cbb_pkg;

  localparam int FUNC_W = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 16;
  localparam int STEP_W = 6;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  // bus commands
  localparam logic [FUNC_W-1:0] CMD_IDLE      = 3'd0;
  localparam logic [FUNC_W-1:0] CMD_START     = 3'd1;
  localparam logic [FUNC_W-1:0] CMD_STOP      = 3'd2;
  localparam logic [FUNC_W-1:0] CMD_WRITE     = 3'd3;
  localparam logic [FUNC_W-1:0] CMD_READ_ACK  = 3'd4;
  localparam logic [FUNC_W-1:0] CMD_READ_NACK = 3'd5;

  // register indexes
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [CNT_W-1:0] HALF_PERIOD_RST = 16'd10;
  localparam logic [CNT_W-1:0] ACK_TIMEOUT_RST = 16'd500;

  // write sequence landmarks
  localparam logic [STEP_W-1:0] WR_BITS_END  = 6'd24;
  localparam logic [STEP_W-1:0] WR_SCL_LOW   = 6'd24;
  localparam logic [STEP_W-1:0] WR_SDA_HIGH  = 6'd25;
  localparam logic [STEP_W-1:0] WR_RELEASE   = 6'd26;
  localparam logic [STEP_W-1:0] WR_POLL      = 6'd27;
  localparam logic [STEP_W-1:0] WR_ACK_HIGH  = 6'd28;
  localparam logic [STEP_W-1:0] WR_ACK_LOW   = 6'd29;

  // read sequence landmarks
  localparam logic [STEP_W-1:0] RD_BITS_END  = 6'd16;
  localparam logic [STEP_W-1:0] RD_RETAKE    = 6'd17;
  localparam logic [STEP_W-1:0] RD_ACK_LEVEL = 6'd18;
  localparam logic [STEP_W-1:0] RD_ACK_HIGH  = 6'd19;

  // number of actions in each command
  function automatic logic [STEP_W-1:0] steps_of(input logic [FUNC_W-1:0] cmd);
    logic [STEP_W-1:0] n;
    case (cmd)
      CMD_START: n = 6'd4;
      CMD_STOP:  n = 6'd3;
      CMD_WRITE: n = 6'd31;
      default:   n = 6'd21;
    endcase
    return n;
  endfunction

  // position within one written bit (SCL low, SDA set, SCL high)
  function automatic logic [1:0] bit_slot(input logic [STEP_W-1:0] s);
    logic [1:0] r;
    case (s)
      6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21: r = 2'd0;
      6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/i2c_bitbang_master.sv]
// Channel   | dir | fields (lowest bit first)
// s_ (in)   | in  | func[2:0], tx_byte[10:3], sda_in[11], zero[15:12]
// m_ (out)  | out | scl, sda, sda_drive, busy, done, ack_seen, rx_byte[13:6], rejected[14]
// cfg       | in  | cfg_we, cfg_addr (0 half period, 1 ack timeout), cfg_wdata[15:0]
//
// One input item is one bus tick; its result item is registered and valid the
// cycle after the input is accepted. Sustained rate is one item per clock while
// results are taken: the whole tick update is one pass of combinational logic
// into the state and output registers.
// A stalled consumer holds one result; s_tready stays low until it is taken.
// rst is synchronous, active high: bus idle, SCL/SDA high, SDA driven.
`include "i2c_bitbang_master_macros.svh"

module i2c_bitbang_master
  import i2cbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // func[2:0], tx_byte[10:3], sda_in[11]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // scl, sda, drive, busy, done, ack, rx[13:6], rej
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  // unpacked input item
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] tx_byte;
  logic              sda_in;
  assign func    = s_tdata[2:0];
  assign tx_byte = s_tdata[10:3];
  assign sda_in  = s_tdata[11];

  logic s_accept;

  // configuration
  logic [CNT_W-1:0] half_period;
  logic [CNT_W-1:0] ack_timeout;

  // engine state
  logic [STEP_W-2:0] phase, phase_next;
  logic [CNT_W-1:0]  hold_count, hold_next;
  logic [CNT_W-1:0]  poll_count, poll_next;
  logic [BYTE_W-1:0] shift_reg, shift_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              drv, drv_next;
  logic              ack_flag, ack_next;
  logic [FUNC_W-1:0] active_cmd, active_next;

  // result fields
  logic              done_out, ack_out, rej_out;
  logic [BYTE_W-1:0] rx_out;
  logic [M_TDATA_W-1:0] m_data_next;

  logic [CNT_W-1:0] hold_load;
  logic [CNT_W-1:0] poll_limit;
  logic             is_cmd;

  assign hold_load  = (half_period == '0) ? '0 : half_period - 16'd1;
  assign poll_limit = (ack_timeout == '0) ? 16'd1 : ack_timeout;
  assign is_cmd     = (func >= CMD_START) && (func <= CMD_READ_NACK);

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    logic              step_req;
    logic [STEP_W-1:0] step_num;
    logic              poll_req;
    logic [CNT_W-1:0]  poll_base;
    logic [CNT_W-1:0]  poll_inc;
    logic              act_req;
    logic [STEP_W-1:0] act_step;
    logic [FUNC_W-1:0] cmd_eff;

    phase_next  = phase;
    hold_next   = hold_count;
    poll_next   = poll_count;
    shift_next  = shift_reg;
    scl_next    = scl;
    sda_next    = sda;
    drv_next    = drv;
    ack_next    = ack_flag;
    active_next = active_cmd;
    done_out    = 1'b0;
    ack_out     = 1'b0;
    rx_out      = '0;
    rej_out     = 1'b0;
    step_req    = 1'b0;
    step_num    = '0;
    poll_req    = 1'b0;
    poll_base   = poll_count;
    act_req     = 1'b0;
    act_step    = '0;
    cmd_eff     = (active_cmd != CMD_IDLE) ? active_cmd : func;

    if (active_cmd != CMD_IDLE) begin
      rej_out = is_cmd;
      if (active_cmd == CMD_WRITE && {1'b0, phase} == WR_POLL) begin
        poll_req = 1'b1;
      end else if (hold_count != '0) begin
        hold_next = hold_count - 16'd1;
      end else begin
        step_req = 1'b1;
        step_num = {1'b0, phase} + 6'd1;
      end
    end else if (is_cmd) begin
      active_next = func;
      ack_next    = 1'b0;
      poll_next   = '0;
      shift_next  = (func == CMD_WRITE) ? tx_byte : '0;
      step_req    = 1'b1;
      step_num    = '0;
    end

    // begin the next action, or finish the command
    if (step_req) begin
      if (step_num >= steps_of(cmd_eff)) begin
        done_out = 1'b1;
      end else begin
        phase_next = step_num[STEP_W-2:0];
        if (cmd_eff == CMD_WRITE && step_num == WR_POLL) begin
          poll_req  = 1'b1;
          poll_base = '0;
        end else begin
          act_req  = 1'b1;
          act_step = step_num;
        end
      end
    end

    // one ACK sample; low SDA or timeout ends the poll and raises SCL
    poll_inc = poll_base + 16'd1;
    if (poll_req) begin
      if (!sda_in) begin
        ack_next = 1'b1;
        act_req  = 1'b1;
      end else begin
        poll_next = poll_inc;
        if (poll_inc >= poll_limit) begin
          ack_next = 1'b0;
          act_req  = 1'b1;
        end
      end
      if (act_req) begin
        act_step   = WR_ACK_HIGH;
        phase_next = WR_ACK_HIGH[STEP_W-2:0];
      end
    end

    // pin action for the current step
    if (act_req) begin
      hold_next = hold_load;
      case (cmd_eff)
        CMD_START: begin
          if (act_step == 6'd0)      scl_next = 1'b1;
          else if (act_step == 6'd1) sda_next = 1'b1;
          else if (act_step == 6'd2) sda_next = 1'b0;
          else                       scl_next = 1'b0;
        end
        CMD_STOP: begin
          if (act_step == 6'd0)      sda_next = 1'b0;
          else if (act_step == 6'd1) scl_next = 1'b1;
          else                       sda_next = 1'b1;
        end
        CMD_WRITE: begin
          if (act_step < WR_BITS_END) begin
            case (bit_slot(act_step))
              2'd0: scl_next = 1'b0;
              2'd1: sda_next = shift_next[BYTE_W-1];
              default: begin
                scl_next   = 1'b1;
                shift_next = {shift_next[BYTE_W-2:0], 1'b0};
              end
            endcase
          end else if (act_step == WR_SCL_LOW)  scl_next = 1'b0;
          else if (act_step == WR_SDA_HIGH)     sda_next = 1'b1;
          else if (act_step == WR_RELEASE)      drv_next = 1'b0;
          else if (act_step == WR_ACK_HIGH)     scl_next = 1'b1;
          else if (act_step == WR_ACK_LOW)      scl_next = 1'b0;
          else                                  drv_next = 1'b1;
        end
        default: begin
          // read: shift in the eight data bits with SDA released, then drive ACK/NACK
          if (act_step == 6'd0) begin
            drv_next = 1'b0;
          end else if (act_step <= RD_BITS_END) begin
            if (act_step[0]) begin
              scl_next = 1'b1;
            end else begin
              shift_next = {shift_next[BYTE_W-2:0], sda_in};
              scl_next   = 1'b0;
            end
          end else if (act_step == RD_RETAKE)    drv_next = 1'b1;
          else if (act_step == RD_ACK_LEVEL)     sda_next = (cmd_eff == CMD_READ_NACK);
          else if (act_step == RD_ACK_HIGH)      scl_next = 1'b1;
          else                                   scl_next = 1'b0;
        end
      endcase
    end

    if (done_out) begin
      if (active_cmd == CMD_WRITE) begin
        ack_out = ack_next;
      end else if (active_cmd == CMD_READ_ACK || active_cmd == CMD_READ_NACK) begin
        rx_out = shift_next;
      end
      active_next = CMD_IDLE;
      phase_next  = '0;
      hold_next   = '0;
    end

    m_data_next = {1'b0, rej_out, rx_out, ack_out, done_out,
                   (active_next != CMD_IDLE), drv_next, sda_next, scl_next};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HALF_PERIOD: half_period <= cfg_wdata;
        REG_ACK_TIMEOUT: ack_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      hold_count <= '0;
      poll_count <= '0;
      shift_reg  <= '0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      drv        <= 1'b1;
      ack_flag   <= 1'b0;
      active_cmd <= CMD_IDLE;
    end else if (s_accept) begin
      phase      <= phase_next;
      hold_count <= hold_next;
      poll_count <= poll_next;
      shift_reg  <= shift_next;
      scl        <= scl_next;
      sda        <= sda_next;
      drv        <= drv_next;
      ack_flag   <= ack_next;
      active_cmd <= active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= m_data_next;
    end
  end

  `I2CBB_ASSERT_NOW(a_idle_clean, active_cmd == CMD_IDLE, phase == '0 && hold_count == '0, "stale step")
  `I2CBB_ASSERT_NOW(a_poll_write, phase == WR_POLL[STEP_W-2:0], active_cmd == CMD_WRITE, "poll outside write")
  `I2CBB_ASSERT_NOW(a_no_overrun, m_tvalid && !m_tready, !s_tready, "input taken while stalled")
  `I2CBB_ASSERT_NEXT(a_reject, s_accept && active_cmd != CMD_IDLE && is_cmd, m_tvalid && m_tdata[14], "no reject flag")

endmodule

[tb/testbench.sv]
module testbench;
  import i2cbb_pkg::*;

  // func codes with no command behind them: plain ticks, never rejected
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  // cycles with no handshake on either side before the run is called dead
  localparam int STALL_LIMIT = 4000;
  // length of the forced receiver hold-off
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] tx_byte;
    logic              sda_in;
  } tick_item_t;

  typedef struct {
    logic              scl;
    logic              sda;
    logic              drive;
    logic              busy;
    logic              done;
    logic              ack;
    logic [BYTE_W-1:0] rx;
    logic              rejected;
  } pin_result_t;

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_t;

  // Tracks the bus engine tick by tick and holds the pin states still owed.
  class i2c_pin_ledger;
    logic [CNT_W-1:0]  half_period;
    logic [CNT_W-1:0]  ack_timeout;
    logic [FUNC_W-1:0] cmd;
    int unsigned       step_no;
    logic [CNT_W-1:0]  hold_left;
    logic [CNT_W-1:0]  polls;
    logic [BYTE_W-1:0] shreg;
    logic              scl, sda, drv, acked;
    bit                finished;
    pin_result_t       pins_due[$];
    int                mismatches;

    function new();
      half_period = HALF_PERIOD_RST;
      ack_timeout = ACK_TIMEOUT_RST;
      cmd = CMD_IDLE;
      step_no = 0;
      hold_left = '0;
      polls = '0;
      shreg = '0;
      scl = 1'b1;
      sda = 1'b1;
      drv = 1'b1;
      acked = 1'b0;
      mismatches = 0;
    endfunction

    function void set_regs(logic [CNT_W-1:0] hp, logic [CNT_W-1:0] to);
      half_period = hp;
      ack_timeout = to;
    endfunction

    function int unsigned action_count(logic [FUNC_W-1:0] c);
      case (c)
        CMD_START: return 4;
        CMD_STOP:  return 3;
        CMD_WRITE: return 31;
        default:   return 21;
      endcase
    endfunction

    function void do_action(int unsigned s, logic sda_i);
      if (cmd == CMD_START) begin
        case (s)
          0: scl = 1'b1;
          1: sda = 1'b1;
          2: sda = 1'b0;
          default: scl = 1'b0;
        endcase
      end else if (cmd == CMD_STOP) begin
        case (s)
          0: sda = 1'b0;
          1: scl = 1'b1;
          default: sda = 1'b1;
        endcase
      end else if (cmd == CMD_WRITE) begin
        if (s < WR_BITS_END) begin
          case (s % 3)
            0: scl = 1'b0;
            1: sda = shreg[7];
            default: begin
              scl = 1'b1;
              shreg = {shreg[6:0], 1'b0};
            end
          endcase
        end else if (s == WR_SCL_LOW) scl = 1'b0;
        else if (s == WR_SDA_HIGH) sda = 1'b1;
        else if (s == WR_RELEASE) drv = 1'b0;
        else if (s == WR_ACK_HIGH) scl = 1'b1;
        else if (s == WR_ACK_LOW) scl = 1'b0;
        else drv = 1'b1;
      end else begin
        if (s == 0) begin
          drv = 1'b0;
        end else if (s <= RD_BITS_END) begin
          if (s % 2 == 1) begin
            scl = 1'b1;
          end else begin
            // sample at the end of the SCL-high hold
            shreg = {shreg[6:0], sda_i};
            scl = 1'b0;
          end
        end else if (s == RD_RETAKE) drv = 1'b1;
        else if (s == RD_ACK_LEVEL) sda = (cmd == CMD_READ_NACK);
        else if (s == RD_ACK_HIGH) scl = 1'b1;
        else scl = 1'b0;
      end
      hold_left = (half_period == 0) ? '0 : half_period - 16'd1;
    endfunction

    // one ACK sample; 1 when polling is over
    function bit poll_once(logic sda_i);
      logic [CNT_W:0] lim;
      lim = (ack_timeout == 0) ? 17'd1 : {1'b0, ack_timeout};
      if (!sda_i) begin
        acked = 1'b1;
        return 1'b1;
      end
      polls = polls + 16'd1;
      if ({1'b0, polls} >= lim) begin
        acked = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void begin_action(int unsigned s, logic sda_i);
      if (s >= action_count(cmd)) begin
        finished = 1'b1;
        return;
      end
      step_no = s;
      if (cmd == CMD_WRITE && s == WR_POLL) begin
        polls = '0;
        if (poll_once(sda_i)) begin
          step_no = WR_ACK_HIGH;
          do_action(step_no, sda_i);
        end
        return;
      end
      do_action(s, sda_i);
    endfunction

    function pin_result_t advance_tick(tick_item_t t);
      pin_result_t r;
      bit is_cmd;
      is_cmd = (t.func >= CMD_START) && (t.func <= CMD_READ_NACK);
      r.rejected = 1'b0;
      r.done = 1'b0;
      r.ack = 1'b0;
      r.rx = '0;
      finished = 1'b0;
      if (cmd != CMD_IDLE) begin
        if (is_cmd) r.rejected = 1'b1;
        if (cmd == CMD_WRITE && step_no == WR_POLL) begin
          if (poll_once(t.sda_in)) begin
            step_no = WR_ACK_HIGH;
            do_action(step_no, t.sda_in);
          end
        end else if (hold_left > 0) begin
          hold_left = hold_left - 16'd1;
        end else begin
          begin_action(step_no + 1, t.sda_in);
        end
        if (finished) begin
          r.done = 1'b1;
          if (cmd == CMD_WRITE) r.ack = acked;
          else if (cmd == CMD_READ_ACK || cmd == CMD_READ_NACK) r.rx = shreg;
          cmd = CMD_IDLE;
          step_no = 0;
          hold_left = '0;
        end
      end else if (is_cmd) begin
        cmd = t.func;
        acked = 1'b0;
        polls = '0;
        shreg = (t.func == CMD_WRITE) ? t.tx_byte : '0;
        begin_action(0, t.sda_in);
      end
      r.scl = scl;
      r.sda = sda;
      r.drive = drv;
      r.busy = (cmd != CMD_IDLE);
      return r;
    endfunction

    function void note_tick(tick_item_t t);
      pins_due.push_back(advance_tick(t));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t ERROR %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_pins(logic [M_TDATA_W-1:0] d);
      pin_result_t want;
      if (pins_due.size() == 0) begin
        mismatches++;
        $display("%0t ERROR unexpected result: expected none, actual %h", $time, d);
        return;
      end
      want = pins_due.pop_front();
      compare_field("scl", want.scl, d[0]);
      compare_field("sda", want.sda, d[1]);
      compare_field("sda_drive", want.drive, d[2]);
      compare_field("busy", want.busy, d[3]);
      compare_field("cmd_done", want.done, d[4]);
      compare_field("ack_seen", want.ack, d[5]);
      compare_field("rx_byte", want.rx, d[13:6]);
      compare_field("cmd_rejected", want.rejected, d[14]);
    endfunction

    function void count_leftovers();
      if (pins_due.size() != 0) begin
        mismatches++;
        $display("%0t ERROR results missing: expected %0d more, actual 0",
                 $time, pins_due.size());
      end
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    function bit busy();
      return cmd != CMD_IDLE;
    endfunction

    // next tick takes an ACK sample
    function bit poll_next();
      return cmd == CMD_WRITE &&
             (step_no == WR_POLL || (step_no == WR_RELEASE && hold_left == 0));
    endfunction

    function int poll_index();
      return (step_no == WR_POLL) ? int'(polls) : 0;
    endfunction

    // next tick is the done tick
    function bit done_next();
      return cmd != CMD_IDLE && !(cmd == CMD_WRITE && step_no == WR_POLL) &&
             hold_left == 0 && step_no + 1 >= action_count(cmd);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // func[2:0], tx_byte[10:3], sda_in[11], zero[15:12]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // scl, sda, drive, busy, done, ack, rx[13:6], rej[14]
  logic                 cfg_we = 1'b0;
  logic                 cfg_addr = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  i2c_pin_ledger led = new();

  // stimulus knobs, set per phase
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  bit        rx_hold_req = 1'b0;
  int        ack_at = 0;         // poll sample on which the slave pulls SDA low
  bit        poll_noisy = 1'b0;  // random SDA during the poll (broken slave)
  sda_mode_t sda_mode = SDA_RANDOM;
  bit        poke_done = 1'b0;   // issue a command on the done tick
  int        noise_pct = 0;      // random func codes while a command runs
  int        ticks_sent = 0;
  int        stall_cycles = 0;

  i2c_bitbang_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random back-pressure, plus a long hold-off on request so the
  // output register fills and s_tready has to drop.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // every accepted result is checked against the oldest predicted pin state
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) led.check_pins(m_tdata);
  end

  // watchdog: only counts cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one tick item, with random idle cycles in front of it. The ledger
  // is updated at the accepting edge, so the caller sees the new state.
  task automatic send_tick(input tick_item_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, t.sda_in, t.tx_byte, t.func};
    do @(posedge clk); while (!s_tready);
    led.note_tick(t);
    ticks_sent++;
  endtask

  // Content of the next tick while a command runs: the slave answers the ACK
  // poll on sample ack_at unless poll_noisy is set, elsewhere SDA follows the chosen mode.
  function automatic tick_item_t next_tick();
    tick_item_t t;
    t.func = CMD_IDLE;
    t.tx_byte = 8'($urandom_range(255));
    if (led.poll_next() && !poll_noisy) begin
      t.sda_in = (led.poll_index() == ack_at) ? 1'b0 : 1'b1;
    end else begin
      case (sda_mode)
        SDA_LOW:  t.sda_in = 1'b0;
        SDA_HIGH: t.sda_in = 1'b1;
        default:  t.sda_in = 1'($urandom_range(1));
      endcase
    end
    if (poke_done && led.done_next()) begin
      t.func = 3'($urandom_range(CMD_READ_NACK, CMD_START));
    end else if ($urandom_range(99) < noise_pct) begin
      t.func = 3'($urandom_range(7));
    end
    return t;
  endfunction

  // one command from idle back to idle
  task automatic run_command(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] tx,
                             input int ack_plan, input sda_mode_t mode, input bit poke,
                             input int noise);
    tick_item_t t;
    ack_at = ack_plan;
    sda_mode = mode;
    poke_done = poke;
    noise_pct = noise;
    t.func = func;
    t.tx_byte = tx;
    t.sda_in = 1'($urandom_range(1));
    send_tick(t);
    while (led.busy()) send_tick(next_tick());
  endtask

  // ACK on the first sample, on the last allowed one, never, or early-random
  function automatic int pick_ack_at();
    int lim;
    lim = (led.ack_timeout == 0) ? 1 : int'(led.ack_timeout);
    case ($urandom_range(3))
      0: return 0;
      1: return lim - 1;
      2: return lim;
      default: return $urandom_range(lim < 24 ? lim : 24);
    endcase
  endfunction

  task automatic random_segment(input int n);
    int first;
    tick_item_t t;
    first = ticks_sent;
    while (ticks_sent - first < n) begin
      if ($urandom_range(9) == 0) begin
        // idle bus tick, sometimes with a spare func code
        case ($urandom_range(2))
          0: t.func = CMD_IDLE;
          1: t.func = FUNC_SPARE_A;
          default: t.func = FUNC_SPARE_B;
        endcase
        t.tx_byte = 8'($urandom_range(255));
        t.sda_in = 1'($urandom_range(1));
        send_tick(t);
      end else begin
        poll_noisy = ($urandom_range(9) == 0);
        run_command(3'($urandom_range(CMD_READ_NACK, CMD_START)), 8'($urandom_range(255)),
                    pick_ack_at(), SDA_RANDOM, $urandom_range(3) == 0, 4);
      end
    end
  endtask

  // registers only change with the engine idle and nothing in flight
  task automatic reconfigure(input logic [CNT_W-1:0] hp, input logic [CNT_W-1:0] to);
    s_tvalid <= 1'b0;
    while (led.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_HALF_PERIOD;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_addr <= REG_ACK_TIMEOUT;
    cfg_wdata <= to;
    @(posedge clk);
    cfg_we <= 1'b0;
    led.set_regs(hp, to);
  endtask

  initial begin
    tick_item_t t;
    logic [CNT_W-1:0] hp, to;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 38;
    rx_idle_pct = 82;

    // idle ticks, spare codes included: pins must sit at their reset levels
    t.tx_byte = 8'hFF;
    t.sda_in = 1'b0;
    t.func = CMD_IDLE;
    send_tick(t);
    t.func = FUNC_SPARE_A;
    send_tick(t);
    t.func = FUNC_SPARE_B;
    t.sda_in = 1'b1;
    send_tick(t);

    // start with reset timing, extra command on the done tick
    run_command(CMD_START, 8'h00, 0, SDA_RANDOM, 1'b1, 0);

    reconfigure(16'd1, 16'd3);
    run_command(CMD_WRITE, 8'hFF, 0, SDA_RANDOM, 1'b0, 0);  // ACK on first sample
    run_command(CMD_WRITE, 8'h00, 2, SDA_RANDOM, 1'b0, 0);  // ACK on last allowed sample
    run_command(CMD_WRITE, 8'hA5, 3, SDA_RANDOM, 1'b0, 0);  // no ACK: timeout
    run_command(CMD_READ_ACK, 8'h00, 0, SDA_HIGH, 1'b0, 0);
    run_command(CMD_READ_NACK, 8'hFF, 0, SDA_LOW, 1'b1, 0);
    run_command(CMD_STOP, 8'h00, 0, SDA_RANDOM, 1'b0, 40);  // commands while busy

    // zero half period and zero timeout behave as one
    reconfigure(16'd0, 16'd0);
    run_command(CMD_WRITE, 8'h5A, 1, SDA_RANDOM, 1'b0, 0);
    run_command(CMD_WRITE, 8'h81, 0, SDA_RANDOM, 1'b0, 0);
    run_command(CMD_READ_ACK, 8'h3C, 0, SDA_RANDOM, 1'b1, 10);

    // random traffic; idling receiver-heavy, then sender-heavy, then none
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin hp = 16'd1; to = 16'd1; end
        1: begin hp = 16'd2; to = 16'd20; end
        2: begin hp = 16'($urandom_range(5, 1)); to = 16'($urandom_range(64, 1)); end
        3: begin hp = 16'd3; to = 16'd8; end
        4: begin hp = 16'd1; to = 16'd40; end
        default: begin hp = 16'($urandom_range(4, 1)); to = 16'($urandom_range(32, 1)); end
      endcase
      reconfigure(hp, to);
      if (seg == 2) begin
        tx_idle_pct = 82;
        rx_idle_pct = 38;
      end else if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;  // sender keeps offering while the result side holds off
      end
      random_segment(160);
    end

    // largest ACK timeout, slave answers a few samples in
    reconfigure(16'd1, 16'hFFFF);
    poll_noisy = 1'b0;
    run_command(CMD_WRITE, 8'hC3, 5, SDA_HIGH, 1'b0, 0);

    s_tvalid <= 1'b0;
    while (led.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    led.count_leftovers();
    if (led.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
